// File: rtl/core/dns_redirect_nat_table_assert.svh
// ----------------------------------------------------------------------------
// DNS redirect NAT table assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DNS_REDIRECT_NAT_TABLE_ASSERT_SVH
`define DNS_REDIRECT_NAT_TABLE_ASSERT_SVH

// same-cycle implication
`define DRNAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DRNAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/drnat_pkg.sv
// ----------------------------------------------------------------------------
// DNS redirect NAT table package
// Word types, register indexes, state codes and the checksum update.
// ----------------------------------------------------------------------------
package drnat_pkg;

  localparam logic [31:0] LoopbackReset = 32'h7F00_0001;
  localparam logic [31:0] HostReset     = 32'h0000_0000;
  localparam logic [15:0] DnsPortReset  = 16'd53;

  typedef enum logic [1:0] {
    REG_LOOPBACK = 2'd0,
    REG_HOST     = 2'd1,
    REG_DNS_PORT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_OUTBOUND = 1'b0,
    OP_INBOUND  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic        operation;
    logic        header_ok;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] ip_check_in;
    logic [15:0] udp_check_in;
  } in_word_t;

  typedef struct packed {
    logic        verdict;
    logic [31:0] new_src_addr;
    logic [31:0] new_dst_addr;
    logic [15:0] ip_check_out;
    logic [15:0] udp_check_out;
    logic        recompute_checksum;
    logic        table_full;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [31:0] wdata;
  } cfg_word_t;

  typedef struct packed {
    logic [31:0] client;
    logic [31:0] server;
    logic [15:0] port;
  } entry_t;

  // one's complement incremental update for a 32-bit field swap
  function automatic logic [15:0] csum_swap32(input logic [15:0] check,
                                              input logic [31:0] old_val,
                                              input logic [31:0] new_val);
    logic [18:0] acc;
    logic [16:0] fold1;
    logic [16:0] fold2;
    acc = {3'b000, ~check} + {3'b000, ~old_val[31:16]} + {3'b000, ~old_val[15:0]}
        + {3'b000, new_val[31:16]} + {3'b000, new_val[15:0]};
    fold1 = {1'b0, acc[15:0]} + {14'd0, acc[18:16]};
    fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
    return ~fold2[15:0];
  endfunction

endpackage

// File: rtl/core/drnat_stream_if.sv
// ----------------------------------------------------------------------------
// DNS redirect NAT table stream channel
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface drnat_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/drnat_cell.sv
// ----------------------------------------------------------------------------
// DNS redirect NAT table cell
// One table entry; rotates to its neighbor during a scan, takes writes after.
// ----------------------------------------------------------------------------
module drnat_cell import drnat_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t prev_i,
  input  logic   wr_en_i,
  input  entry_t wr_entry_i,
  input  logic   clr_i,
  output entry_t entry_o
);

  entry_t      entry_d;
  entry_t      entry_q;
  logic [31:0] client_q;
  logic [31:0] server_q;
  logic [15:0] port_q;

  assign entry_q = '{client: client_q, server: server_q, port: port_q};

  always_comb begin
    entry_d = entry_q;
    priority if (shift_i) begin
      entry_d = prev_i;
    end else if (wr_en_i) begin
      entry_d = wr_entry_i;
    end else if (clr_i) begin
      entry_d.port = '0;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    client_q <= entry_d.client;
    server_q <= entry_d.server;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q <= '0;
    end else begin
      port_q <= entry_d.port;
    end
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/core/drnat_scan.sv
// ----------------------------------------------------------------------------
// DNS redirect NAT table scan head
// Inspects the entry at the head of the ring each cycle; keeps the first free
// slot in probe order and the lowest matching slot.
// ----------------------------------------------------------------------------
module drnat_scan import drnat_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             step_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] slot_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] next_slot_i,
  input  entry_t                           head_i,
  input  logic [31:0]                      client_i,
  input  logic [31:0]                      server_i,
  input  logic [15:0]                      port_i,
  output logic                             free_found_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] free_idx_o,
  output logic                             match_found_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] match_idx_o,
  output logic [31:0]                      match_server_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  logic            head_free;
  logic            head_hit;
  logic            hi_found_d, hi_found_q;
  logic            lo_found_d, lo_found_q;
  logic            match_found_d, match_found_q;
  logic [IdxW-1:0] hi_idx_d, hi_idx_q;
  logic [IdxW-1:0] lo_idx_d, lo_idx_q;
  logic [IdxW-1:0] match_idx_d, match_idx_q;
  logic [31:0]     match_server_d, match_server_q;

  assign head_free = (head_i.port == '0);
  assign head_hit  = !head_free && (head_i.client == client_i) &&
                     (head_i.server == server_i) && (head_i.port == port_i);

  always_comb begin
    hi_found_d     = hi_found_q;
    lo_found_d     = lo_found_q;
    match_found_d  = match_found_q;
    hi_idx_d       = hi_idx_q;
    lo_idx_d       = lo_idx_q;
    match_idx_d    = match_idx_q;
    match_server_d = match_server_q;
    if (start_i) begin
      hi_found_d    = 1'b0;
      lo_found_d    = 1'b0;
      match_found_d = 1'b0;
    end else if (step_i) begin
      if (head_free && !hi_found_q && (slot_i > next_slot_i)) begin
        hi_found_d = 1'b1;
        hi_idx_d   = slot_i;
      end
      if (head_free && !lo_found_q && (slot_i <= next_slot_i)) begin
        lo_found_d = 1'b1;
        lo_idx_d   = slot_i;
      end
      if (head_hit && !match_found_q) begin
        match_found_d  = 1'b1;
        match_idx_d    = slot_i;
        match_server_d = head_i.server;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_found_q    <= 1'b0;
      lo_found_q    <= 1'b0;
      match_found_q <= 1'b0;
    end else begin
      hi_found_q    <= hi_found_d;
      lo_found_q    <= lo_found_d;
      match_found_q <= match_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_idx_q       <= hi_idx_d;
    lo_idx_q       <= lo_idx_d;
    match_idx_q    <= match_idx_d;
    match_server_q <= match_server_d;
  end

  assign free_found_o   = hi_found_q || lo_found_q;
  assign free_idx_o     = hi_found_q ? hi_idx_q : lo_idx_q;
  assign match_found_o  = match_found_q;
  assign match_idx_o    = match_idx_q;
  assign match_server_o = match_server_q;

endmodule

// File: rtl/core/dns_redirect_nat_table.sv
// ----------------------------------------------------------------------------
// DNS redirect NAT table
// One header summary in, one verdict word out. Outbound DNS queries are
// logged and redirected to the host; inbound replies are matched and restored.
// ----------------------------------------------------------------------------
// The table is a ring of TABLE_ENTRIES cells that rotates one place per cycle
// past a single compare head. Each word is loaded, then scanned while the ring
// comes full circle, then written back with its result loaded into the output
// register; that step waits while the register holds a result not yet taken.
// The result sits in an output register, so the next word is taken while it
// waits. Configuration writes are always ready and take effect on the next
// word; write them only while no word is in flight.
module dns_redirect_nat_table import drnat_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input logic             clk_i,
  input logic             rst_ni,
  drnat_stream_if.sink    in_i,
  drnat_stream_if.source  out_o,
  drnat_stream_if.sink    cfg_i
);

  localparam int unsigned     IdxW     = $clog2(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(TABLE_ENTRIES - 1);

  state_e          state_d, state_q;
  logic [IdxW-1:0] ctr_d, ctr_q;
  logic [IdxW-1:0] next_slot_d, next_slot_q;
  logic [31:0]     loopback_d, loopback_q;
  logic [31:0]     host_d, host_q;
  logic [15:0]     dns_port_d, dns_port_q;
  in_word_t        item_d, item_q;
  out_word_t       out_d, out_q;
  logic            out_valid_d, out_valid_q;

  logic            in_acc;
  logic            out_free;
  logic            commit;
  logic            src_local;
  logic            dst_local;
  logic            is_query;
  logic            reply_path;
  logic            is_reply;
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  logic            match_found;
  logic [IdxW-1:0] match_idx;
  logic [31:0]     match_server;
  entry_t          wr_entry;
  entry_t          entries [TABLE_ENTRIES];

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign commit      = (state_q == ST_DONE) && out_free;

  assign src_local  = (item_q.src_addr == host_q) || (item_q.src_addr == loopback_q);
  assign dst_local  = (item_q.dst_addr == host_q) || (item_q.dst_addr == loopback_q);
  assign is_query   = item_q.header_ok && (item_q.operation == OP_OUTBOUND) &&
                      !src_local && (item_q.dst_port == dns_port_q);
  assign reply_path = item_q.header_ok && (item_q.operation == OP_INBOUND) && !dst_local;
  assign is_reply   = reply_path && (item_q.src_port == dns_port_q);

  assign wr_entry = '{client: item_q.src_addr, server: item_q.dst_addr,
                      port: item_q.src_port};

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    drnat_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (state_q == ST_SCAN),
      .prev_i     (entries[(i + 1) % TABLE_ENTRIES]),
      .wr_en_i    (commit && is_query && free_found && (free_idx == IdxW'(i))),
      .wr_entry_i (wr_entry),
      .clr_i      (commit && is_reply && match_found && (match_idx == IdxW'(i))),
      .entry_o    (entries[i])
    );
  end

  drnat_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (in_acc),
    .step_i         (state_q == ST_SCAN),
    .slot_i         (ctr_q),
    .next_slot_i    (next_slot_q),
    .head_i         (entries[0]),
    .client_i       (item_q.dst_addr),
    .server_i       (item_q.src_addr),
    .port_i         (item_q.dst_port),
    .free_found_o   (free_found),
    .free_idx_o     (free_idx),
    .match_found_o  (match_found),
    .match_idx_o    (match_idx),
    .match_server_o (match_server)
  );

  always_comb begin
    loopback_d = loopback_q;
    host_d     = host_q;
    dns_port_d = dns_port_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.data.reg_index))
        REG_LOOPBACK: loopback_d = cfg_i.data.wdata;
        REG_HOST:     host_d     = cfg_i.data.wdata;
        REG_DNS_PORT: dns_port_d = cfg_i.data.wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    ctr_d       = ctr_q;
    next_slot_d = next_slot_q;
    item_d      = item_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          item_d  = in_i.data;
          ctr_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctr_d = ctr_q + 1'b1;
        if (ctr_q == LastSlot) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          if (is_query && free_found) begin
            next_slot_d = free_idx;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_d.verdict            = reply_path && (!is_reply || !match_found);
    out_d.new_src_addr       = (is_reply && match_found) ? match_server : item_q.src_addr;
    out_d.new_dst_addr       = is_query ? host_q : item_q.dst_addr;
    out_d.ip_check_out       = is_query ?
                               csum_swap32(item_q.ip_check_in, item_q.dst_addr, host_q) :
                               item_q.ip_check_in;
    out_d.udp_check_out      = is_query ?
                               csum_swap32(item_q.udp_check_in, item_q.dst_addr, host_q) :
                               item_q.udp_check_in;
    out_d.recompute_checksum = is_reply && match_found;
    out_d.table_full         = is_query && !free_found;
    out_valid_d              = commit ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ctr_q       <= '0;
      next_slot_q <= '0;
      loopback_q  <= LoopbackReset;
      host_q      <= HostReset;
      dns_port_q  <= DnsPortReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      next_slot_q <= next_slot_d;
      loopback_q  <= loopback_d;
      host_q      <= host_d;
      dns_port_q  <= dns_port_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// File: rtl/core/drnat_checker.sv
// ----------------------------------------------------------------------------
// DNS redirect NAT table checker
// Port-level checks on the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "dns_redirect_nat_table_assert.svh"

module drnat_checker import drnat_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_data_i
);

  `DRNAT_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i, "input ready right after accept")
  `DRNAT_ASSERT_NXT(a_out_valid_hold, out_valid_i && !out_ready_i, out_valid_i, "result word dropped while stalled")
  `DRNAT_ASSERT_NXT(a_out_data_hold, out_valid_i && !out_ready_i, $stable(out_data_i), "result word changed while stalled")
  `DRNAT_ASSERT_IMP(a_restore_accepts, out_valid_i && out_data_i.recompute_checksum, !out_data_i.verdict && !out_data_i.table_full, "restored reply not accepted cleanly")

endmodule

bind dns_redirect_nat_table drnat_checker u_drnat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
